// File: rtl/core/qvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_pkg
// Shared types, widths and helpers for the quad vertex transform block.
// ----------------------------------------------------------------------------
package qvt_pkg;

   localparam int MAX_QUADS   = 8192;
   localparam int COUNT_W     = 14;
   localparam int SLOT_W      = 15;
   localparam int INDEX_W     = 16;
   localparam int POS_W       = 24;
   localparam int CRD_W       = 25;
   localparam int COEF_W      = 16;
   localparam int ROW_W       = 48;
   localparam int SHIFT_W     = 32;
   localparam int VERT_W      = 32;
   localparam int COLOR_W     = 32;
   localparam int CHAN_W      = 9;
   localparam int PROD_W      = COEF_W + CRD_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int FRAC_W      = 8;
   localparam int DIV_W       = SUM_W - FRAC_W;
   localparam int ACC_W       = DIV_W + 1;
   localparam int CSR_ADDR_W  = 6;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   typedef enum logic [1:0] {
      KIND_VERTEX = 2'd0,
      KIND_FLUSH  = 2'd1,
      KIND_DROP   = 2'd2
   } kind_type;

   typedef enum logic {
      ACT_SUBMIT = 1'b0,
      ACT_FLUSH  = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ROW_X   = 3'd0,
      REG_ROW_Y   = 3'd1,
      REG_ROW_Z   = 3'd2,
      REG_SHIFT_X = 3'd3,
      REG_SHIFT_Y = 3'd4,
      REG_SHIFT_Z = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [ROW_W-1:0]          row_x;
      logic [ROW_W-1:0]          row_y;
      logic [ROW_W-1:0]          row_z;
      logic signed [SHIFT_W-1:0] shift_x;
      logic signed [SHIFT_W-1:0] shift_y;
      logic signed [SHIFT_W-1:0] shift_z;
   } xform_type;

   typedef struct packed {
      kind_type                kind;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic signed [CRD_W-1:0] end_x;
      logic signed [CRD_W-1:0] end_y;
      logic [COLOR_W-1:0]      color;
      logic [SLOT_W-1:0]       slot_base;
      logic [INDEX_W-1:0]      index_total;
   } cmd_type;

   typedef struct packed {
      kind_type           kind;
      logic [COLOR_W-1:0] color;
      logic [SLOT_W-1:0]  slot;
      logic [INDEX_W-1:0] index_total;
      logic               last;
   } meta_type;

   // v * 255 / 256, clamped to a byte
   function automatic logic [7:0] channel_byte(input logic [CHAN_W-1:0] v);
      logic [CHAN_W+7:0] prod;
      prod = {v, 8'd0} - {8'd0, v};
      if (prod[CHAN_W+7]) begin
         return 8'hFF;
      end
      return prod[CHAN_W+6:8];
   endfunction

endpackage

// File: rtl/core/quad_vertex_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_vertex_transform
// Sprite quad vertex generator with a configurable fixed-point affine map.
// ----------------------------------------------------------------------------
// Request side is a queue: a word is taken when push is high and full is low.
// A submit word yields four vertex words (corners origin, +h, +w+h, +w), the
// last one marked; a flush yields one report word with six indices per quad
// and clears the count; a submit with the batch full yields one drop word.
// Result side is a queue: while empty is low the oldest word is on the rsp_
// ports, and pop takes it.
// A word accepted on the request side passes the command queue and then the
// back-end stages a (corner coordinates), b (products), c (sums) and out.
// Results leave at one per cycle while pop is high; a submit yields four
// result words, and the corner walk in the back end sets the submit rate. A
// two-entry command queue lets the front keep taking words while the back end
// works. When a result word waits and pop is low the whole back-end pipeline
// holds; full rises once the command queue fills. Reset clears the quad count,
// the queues and the registers (identity matrix, zero translation).
// ----------------------------------------------------------------------------
module quad_vertex_transform (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic                                  req_action,
   input  logic signed [qvt_pkg::POS_W-1:0]      req_pos_x,
   input  logic signed [qvt_pkg::POS_W-1:0]      req_pos_y,
   input  logic signed [qvt_pkg::POS_W-1:0]      req_pos_z,
   input  logic signed [qvt_pkg::POS_W-1:0]      req_width,
   input  logic signed [qvt_pkg::POS_W-1:0]      req_height,
   input  logic [qvt_pkg::CHAN_W-1:0]            req_red,
   input  logic [qvt_pkg::CHAN_W-1:0]            req_green,
   input  logic [qvt_pkg::CHAN_W-1:0]            req_blue,
   input  logic [qvt_pkg::CHAN_W-1:0]            req_alpha,
   output logic                                  empty,
   input  logic                                  pop,
   output logic [1:0]                            rsp_kind,
   output logic signed [qvt_pkg::VERT_W-1:0]     rsp_vert_x,
   output logic signed [qvt_pkg::VERT_W-1:0]     rsp_vert_y,
   output logic signed [qvt_pkg::VERT_W-1:0]     rsp_vert_z,
   output logic [qvt_pkg::COLOR_W-1:0]           rsp_color_word,
   output logic [qvt_pkg::SLOT_W-1:0]            rsp_vertex_slot,
   output logic [qvt_pkg::INDEX_W-1:0]           rsp_index_total,
   output logic                                  rsp_last,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [qvt_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [qvt_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [qvt_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                  pready
);

   qvt_pkg::xform_type xf_ff;
   qvt_pkg::cmd_type   front_cmd;
   qvt_pkg::cmd_type   head_cmd;
   qvt_pkg::csr_reg_type csr_idx;
   logic               csr_wr;
   logic               front_push;
   logic               head_valid;
   logic               head_pop;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = qvt_pkg::csr_reg_type'(paddr[qvt_pkg::CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         xf_ff.row_x   <= qvt_pkg::ROW_W'(48'h0000_0000_0100);
         xf_ff.row_y   <= qvt_pkg::ROW_W'(48'h0000_0100_0000);
         xf_ff.row_z   <= qvt_pkg::ROW_W'(48'h0100_0000_0000);
         xf_ff.shift_x <= '0;
         xf_ff.shift_y <= '0;
         xf_ff.shift_z <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            qvt_pkg::REG_ROW_X:   xf_ff.row_x   <= pwdata[qvt_pkg::ROW_W-1:0];
            qvt_pkg::REG_ROW_Y:   xf_ff.row_y   <= pwdata[qvt_pkg::ROW_W-1:0];
            qvt_pkg::REG_ROW_Z:   xf_ff.row_z   <= pwdata[qvt_pkg::ROW_W-1:0];
            qvt_pkg::REG_SHIFT_X: xf_ff.shift_x <= pwdata[qvt_pkg::SHIFT_W-1:0];
            qvt_pkg::REG_SHIFT_Y: xf_ff.shift_y <= pwdata[qvt_pkg::SHIFT_W-1:0];
            qvt_pkg::REG_SHIFT_Z: xf_ff.shift_z <= pwdata[qvt_pkg::SHIFT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         qvt_pkg::REG_ROW_X:   prdata = qvt_pkg::CSR_DATA_W'(xf_ff.row_x);
         qvt_pkg::REG_ROW_Y:   prdata = qvt_pkg::CSR_DATA_W'(xf_ff.row_y);
         qvt_pkg::REG_ROW_Z:   prdata = qvt_pkg::CSR_DATA_W'(xf_ff.row_z);
         qvt_pkg::REG_SHIFT_X: prdata = qvt_pkg::CSR_DATA_W'(unsigned'(xf_ff.shift_x));
         qvt_pkg::REG_SHIFT_Y: prdata = qvt_pkg::CSR_DATA_W'(unsigned'(xf_ff.shift_y));
         qvt_pkg::REG_SHIFT_Z: prdata = qvt_pkg::CSR_DATA_W'(unsigned'(xf_ff.shift_z));
         default:              prdata = '0;
      endcase
   end

   qvt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .q_full     (full),
      .req_action (req_action),
      .req_pos_x  (req_pos_x),
      .req_pos_y  (req_pos_y),
      .req_pos_z  (req_pos_z),
      .req_width  (req_width),
      .req_height (req_height),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .req_alpha  (req_alpha),
      .cmd_push   (front_push),
      .cmd        (front_cmd)
   );

   qvt_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (front_push),
      .wr_cmd   (front_cmd),
      .q_full   (full),
      .rd_en    (head_pop),
      .rd_valid (head_valid),
      .rd_cmd   (head_cmd)
   );

   qvt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .xf              (xf_ff),
      .cmd_valid       (head_valid),
      .cmd             (head_cmd),
      .cmd_pop         (head_pop),
      .pop             (pop),
      .empty           (empty),
      .rsp_kind        (rsp_kind),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_color_word  (rsp_color_word),
      .rsp_vertex_slot (rsp_vertex_slot),
      .rsp_index_total (rsp_index_total),
      .rsp_last        (rsp_last)
   );

endmodule

// File: rtl/core/qvt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_front
// Accepts request words, classifies them, keeps the quad count and forms
// the command handed to the vertex back end.
// ----------------------------------------------------------------------------
module qvt_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic                             q_full,
   input  logic                             req_action,
   input  logic signed [qvt_pkg::POS_W-1:0] req_pos_x,
   input  logic signed [qvt_pkg::POS_W-1:0] req_pos_y,
   input  logic signed [qvt_pkg::POS_W-1:0] req_pos_z,
   input  logic signed [qvt_pkg::POS_W-1:0] req_width,
   input  logic signed [qvt_pkg::POS_W-1:0] req_height,
   input  logic [qvt_pkg::CHAN_W-1:0]       req_red,
   input  logic [qvt_pkg::CHAN_W-1:0]       req_green,
   input  logic [qvt_pkg::CHAN_W-1:0]       req_blue,
   input  logic [qvt_pkg::CHAN_W-1:0]       req_alpha,
   output logic                             cmd_push,
   output qvt_pkg::cmd_type                 cmd
);

   logic [qvt_pkg::COUNT_W-1:0]   quad_count_ff;
   logic [qvt_pkg::COUNT_W-1:0]   quad_count_in;
   logic [qvt_pkg::INDEX_W:0]     total;
   logic                          batch_full;

   assign cmd_push   = push && !q_full;
   assign batch_full = quad_count_ff >= qvt_pkg::COUNT_W'(qvt_pkg::MAX_QUADS);
   assign total      = (qvt_pkg::INDEX_W+1)'(quad_count_ff) * (qvt_pkg::INDEX_W+1)'(6);

   always_comb begin
      cmd             = '0;
      cmd.pos_x       = req_pos_x;
      cmd.pos_y       = req_pos_y;
      cmd.pos_z       = req_pos_z;
      cmd.end_x       = qvt_pkg::CRD_W'(req_pos_x) + qvt_pkg::CRD_W'(req_width);
      cmd.end_y       = qvt_pkg::CRD_W'(req_pos_y) + qvt_pkg::CRD_W'(req_height);
      quad_count_in   = quad_count_ff;
      if (req_action == qvt_pkg::ACT_FLUSH) begin
         cmd.kind        = qvt_pkg::KIND_FLUSH;
         cmd.index_total = total[qvt_pkg::INDEX_W] ? '1 : total[qvt_pkg::INDEX_W-1:0];
         quad_count_in   = '0;
      end else if (batch_full) begin
         cmd.kind = qvt_pkg::KIND_DROP;
      end else begin
         cmd.kind      = qvt_pkg::KIND_VERTEX;
         cmd.color     = {qvt_pkg::channel_byte(req_alpha), qvt_pkg::channel_byte(req_blue),
                          qvt_pkg::channel_byte(req_green), qvt_pkg::channel_byte(req_red)};
         cmd.slot_base = {quad_count_ff[qvt_pkg::SLOT_W-3:0], 2'b00};
         quad_count_in = quad_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quad_count_ff <= '0;
      end else if (cmd_push) begin
         quad_count_ff <= quad_count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      quad_count_ff <= qvt_pkg::COUNT_W'(qvt_pkg::MAX_QUADS))
      else $error("quad count beyond batch limit");

endmodule

// File: rtl/core/qvt_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_cmd_queue
// Two-entry command queue between the front end and the vertex back end.
// ----------------------------------------------------------------------------
module qvt_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  qvt_pkg::cmd_type wr_cmd,
   output logic             q_full,
   input  logic             rd_en,
   output logic             rd_valid,
   output qvt_pkg::cmd_type rd_cmd
);

   qvt_pkg::cmd_type            entry_ff [qvt_pkg::QUEUE_DEPTH];
   logic [qvt_pkg::QPTR_W-1:0]  wr_ptr_ff;
   logic [qvt_pkg::QPTR_W-1:0]  rd_ptr_ff;
   logic [qvt_pkg::QCNT_W-1:0]  count_ff;

   assign q_full   = count_ff == qvt_pkg::QCNT_W'(qvt_pkg::QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_cmd   = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + qvt_pkg::QCNT_W'(wr_en) - qvt_pkg::QCNT_W'(rd_en);
      end
   end

endmodule

// File: rtl/core/qvt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvt_back
// Vertex back end: walks the four corners of a submit, multiplies by the
// matrix, sums, rounds down, translates, saturates and holds the result word.
// ----------------------------------------------------------------------------
module qvt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  qvt_pkg::xform_type                xf,
   input  logic                              cmd_valid,
   input  qvt_pkg::cmd_type                  cmd,
   output logic                              cmd_pop,
   input  logic                              pop,
   output logic                              empty,
   output logic [1:0]                        rsp_kind,
   output logic signed [qvt_pkg::VERT_W-1:0] rsp_vert_x,
   output logic signed [qvt_pkg::VERT_W-1:0] rsp_vert_y,
   output logic signed [qvt_pkg::VERT_W-1:0] rsp_vert_z,
   output logic [qvt_pkg::COLOR_W-1:0]       rsp_color_word,
   output logic [qvt_pkg::SLOT_W-1:0]        rsp_vertex_slot,
   output logic [qvt_pkg::INDEX_W-1:0]       rsp_index_total,
   output logic                              rsp_last
);

   logic adv;
   logic issue;
   logic done;

   logic [1:0] corner_ff;
   logic [1:0] corner_in;

   logic a_valid_ff;
   logic b_valid_ff;
   logic c_valid_ff;
   logic out_valid_ff;

   qvt_pkg::meta_type a_meta_ff, a_meta_in;
   qvt_pkg::meta_type b_meta_ff;
   qvt_pkg::meta_type c_meta_ff;
   qvt_pkg::meta_type out_meta_ff, out_meta_in;

   logic signed [qvt_pkg::CRD_W-1:0]  crd_ff  [3];
   logic signed [qvt_pkg::CRD_W-1:0]  crd_in  [3];
   logic signed [qvt_pkg::PROD_W-1:0] prod_ff [3][3];
   logic signed [qvt_pkg::PROD_W-1:0] prod_in [3][3];
   logic signed [qvt_pkg::DIV_W-1:0]  div_ff  [3];
   logic signed [qvt_pkg::DIV_W-1:0]  div_in  [3];
   logic signed [qvt_pkg::VERT_W-1:0] vert_ff [3];
   logic signed [qvt_pkg::VERT_W-1:0] vert_in [3];

   logic [qvt_pkg::ROW_W-1:0]          rows [3];
   logic signed [qvt_pkg::SHIFT_W-1:0] shifts [3];

   assign rows[0]   = xf.row_x;
   assign rows[1]   = xf.row_y;
   assign rows[2]   = xf.row_z;
   assign shifts[0] = xf.shift_x;
   assign shifts[1] = xf.shift_y;
   assign shifts[2] = xf.shift_z;

   assign adv     = !out_valid_ff || pop;
   assign issue   = adv && cmd_valid;
   assign done    = (cmd.kind != qvt_pkg::KIND_VERTEX) || (corner_ff == 2'd3);
   assign cmd_pop = issue && done;
   assign empty   = !out_valid_ff;

   // corner order: origin, +h, +w+h, +w
   always_comb begin
      corner_in = corner_ff;
      if (issue) begin
         corner_in = done ? 2'd0 : corner_ff + 2'd1;
      end
      crd_in[0] = corner_ff[1] ? cmd.end_x : qvt_pkg::CRD_W'(cmd.pos_x);
      crd_in[1] = (corner_ff == 2'd1 || corner_ff == 2'd2) ? cmd.end_y
                                                          : qvt_pkg::CRD_W'(cmd.pos_y);
      crd_in[2] = qvt_pkg::CRD_W'(cmd.pos_z);
      a_meta_in.kind        = cmd.kind;
      a_meta_in.color       = cmd.color;
      a_meta_in.slot        = cmd.slot_base + qvt_pkg::SLOT_W'(corner_ff);
      a_meta_in.index_total = cmd.index_total;
      a_meta_in.last        = done;
   end

   always_comb begin
      logic signed [qvt_pkg::COEF_W-1:0] coef;
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            coef = signed'(rows[r][qvt_pkg::COEF_W*k +: qvt_pkg::COEF_W]);
            prod_in[r][k] = qvt_pkg::PROD_W'(coef) * qvt_pkg::PROD_W'(crd_ff[k]);
         end
      end
   end

   always_comb begin
      logic signed [qvt_pkg::SUM_W-1:0] sum;
      for (int r = 0; r < 3; r++) begin
         sum = qvt_pkg::SUM_W'(prod_ff[r][0]) + qvt_pkg::SUM_W'(prod_ff[r][1])
             + qvt_pkg::SUM_W'(prod_ff[r][2]);
         div_in[r] = sum[qvt_pkg::SUM_W-1:qvt_pkg::FRAC_W];
      end
   end

   always_comb begin
      logic signed [qvt_pkg::ACC_W-1:0] acc;
      out_meta_in = c_meta_ff;
      for (int r = 0; r < 3; r++) begin
         acc = qvt_pkg::ACC_W'(div_ff[r]) + qvt_pkg::ACC_W'(shifts[r]);
         if (acc[qvt_pkg::ACC_W-1:qvt_pkg::VERT_W-1] != '0 &&
             acc[qvt_pkg::ACC_W-1:qvt_pkg::VERT_W-1] != '1) begin
            vert_in[r] = acc[qvt_pkg::ACC_W-1] ? {1'b1, {(qvt_pkg::VERT_W-1){1'b0}}}
                                               : {1'b0, {(qvt_pkg::VERT_W-1){1'b1}}};
         end else begin
            vert_in[r] = acc[qvt_pkg::VERT_W-1:0];
         end
         if (c_meta_ff.kind != qvt_pkg::KIND_VERTEX) begin
            vert_in[r] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         corner_ff <= corner_in;
         if (adv) begin
            a_valid_ff   <= issue;
            b_valid_ff   <= a_valid_ff;
            c_valid_ff   <= b_valid_ff;
            out_valid_ff <= c_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_meta_ff   <= a_meta_in;
         b_meta_ff   <= a_meta_ff;
         c_meta_ff   <= b_meta_ff;
         out_meta_ff <= out_meta_in;
         crd_ff      <= crd_in;
         prod_ff     <= prod_in;
         div_ff      <= div_in;
         vert_ff     <= vert_in;
      end
   end

   assign rsp_kind        = out_meta_ff.kind;
   assign rsp_vert_x      = vert_ff[0];
   assign rsp_vert_y      = vert_ff[1];
   assign rsp_vert_z      = vert_ff[2];
   assign rsp_color_word  = out_meta_ff.color;
   assign rsp_vertex_slot = out_meta_ff.slot;
   assign rsp_index_total = out_meta_ff.index_total;
   assign rsp_last        = out_meta_ff.last;

   a_corner_head: assert property (@(posedge clock) disable iff (reset)
      corner_ff != 2'd0 |-> cmd_valid && cmd.kind == qvt_pkg::KIND_VERTEX)
      else $error("corner walk without a quad at queue head");

   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && a_meta_ff.kind == qvt_pkg::KIND_VERTEX |->
         a_meta_ff.last == (a_meta_ff.slot[1:0] == 2'd3))
      else $error("last mark not on fourth corner");

   a_single_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_meta_ff.kind != qvt_pkg::KIND_VERTEX |->
         out_meta_ff.last && vert_ff[0] == '0 && vert_ff[1] == '0 && vert_ff[2] == '0)
      else $error("report word malformed");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the quad vertex transform block.
// ----------------------------------------------------------------------------
// Rectangles and flushes are queued by the sequence below and offered on the
// request side by a falling-edge driver. Every accepted word is run through a
// local transform and batch model, and the words it must produce are queued.
// A rising-edge monitor checks each popped result word against the
// oldest queued word. The run covers identity and extreme matrices, random
// traffic under several idle and stall mixes, and a long result-side hold
// that backs the block up.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      qvt_pkg::action_type                  action;
      logic signed [qvt_pkg::POS_W-1:0]     pos_x, pos_y, pos_z, size_w, size_h;
      logic [qvt_pkg::CHAN_W-1:0]           red, green, blue, alpha;
   } rect_word_type;

   typedef struct packed {
      qvt_pkg::kind_type           kind;
      logic [qvt_pkg::VERT_W-1:0]  vx, vy, vz;
      logic [qvt_pkg::COLOR_W-1:0] color;
      logic [qvt_pkg::SLOT_W-1:0]  slot;
      logic [qvt_pkg::INDEX_W-1:0] index;
      logic                        last;
   } vertex_word_type;

   localparam logic signed [qvt_pkg::POS_W-1:0] POS_HI = 24'sh7FFFFF;
   localparam logic signed [qvt_pkg::POS_W-1:0] POS_LO = 24'sh800000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [qvt_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [qvt_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [qvt_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;
   logic [1:0] rsp_kind;
   logic signed [qvt_pkg::VERT_W-1:0] rsp_vert_x, rsp_vert_y, rsp_vert_z;
   logic [qvt_pkg::COLOR_W-1:0] rsp_color_word;
   logic [qvt_pkg::SLOT_W-1:0] rsp_vertex_slot;
   logic [qvt_pkg::INDEX_W-1:0] rsp_index_total;
   logic rsp_last;

   rect_word_type offer = '0;

   rect_word_type   rect_queue[$];
   vertex_word_type due_words[$];

   // model copy of the transform registers and the batch count
   logic [qvt_pkg::ROW_W-1:0] mat_row[3] = '{48'd256, 48'd16777216, 48'd1099511627776};
   logic signed [qvt_pkg::SHIFT_W-1:0] offset[3] = '{32'sd0, 32'sd0, 32'sd0};
   logic [qvt_pkg::COUNT_W-1:0] quad_tally = '0;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int          hold_req = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          errors = 0;
   bit          took_req = 1'b0;

   quad_vertex_transform DUT (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (offer.action),
      .req_pos_x       (offer.pos_x),
      .req_pos_y       (offer.pos_y),
      .req_pos_z       (offer.pos_z),
      .req_width       (offer.size_w),
      .req_height      (offer.size_h),
      .req_red         (offer.red),
      .req_green       (offer.green),
      .req_blue        (offer.blue),
      .req_alpha       (offer.alpha),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_color_word  (rsp_color_word),
      .rsp_vertex_slot (rsp_vertex_slot),
      .rsp_index_total (rsp_index_total),
      .rsp_last        (rsp_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor(row . (x,y,z) / 256) + shift, saturated to 32 bits
   function automatic logic [qvt_pkg::VERT_W-1:0] map_axis(
         input logic [qvt_pkg::ROW_W-1:0] row,
         input logic signed [qvt_pkg::SHIFT_W-1:0] shift,
         input longint x, input longint y, input longint z);
      longint c0, c1, c2, acc;
      c0 = longint'($signed(row[15:0]));
      c1 = longint'($signed(row[31:16]));
      c2 = longint'($signed(row[47:32]));
      acc = ((c0 * x + c1 * y + c2 * z) >>> 8) + longint'(shift);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc[qvt_pkg::VERT_W-1:0];
   endfunction

   function automatic logic [7:0] scale_channel(input logic [qvt_pkg::CHAN_W-1:0] v);
      int p;
      p = (int'(v) * 255) >> 8;
      if (p > 255) p = 255;
      return p[7:0];
   endfunction

   task automatic emit_quad_words(input rect_word_type w);
      vertex_word_type e;
      longint px, py, pz, cx, cy;
      int total, k;
      e = '0;
      e.last = 1'b1;
      if (w.action == qvt_pkg::ACT_FLUSH) begin
         total = int'(quad_tally) * 6;
         e.kind = qvt_pkg::KIND_FLUSH;
         e.index = (total > 65535) ? 16'hFFFF : total[qvt_pkg::INDEX_W-1:0];
         due_words.push_back(e);
         quad_tally = '0;
      end else if (int'(quad_tally) >= qvt_pkg::MAX_QUADS) begin
         e.kind = qvt_pkg::KIND_DROP;
         due_words.push_back(e);
      end else begin
         px = longint'($signed(w.pos_x));
         py = longint'($signed(w.pos_y));
         pz = longint'($signed(w.pos_z));
         e.kind = qvt_pkg::KIND_VERTEX;
         e.color = {scale_channel(w.alpha), scale_channel(w.blue),
                    scale_channel(w.green), scale_channel(w.red)};
         for (k = 0; k < 4; k++) begin
            cx = (k >= 2) ? px + longint'($signed(w.size_w)) : px;
            cy = (k == 1 || k == 2) ? py + longint'($signed(w.size_h)) : py;
            e.vx = map_axis(mat_row[0], offset[0], cx, cy, pz);
            e.vy = map_axis(mat_row[1], offset[1], cx, cy, pz);
            e.vz = map_axis(mat_row[2], offset[2], cx, cy, pz);
            e.slot = qvt_pkg::SLOT_W'(int'(quad_tally) * 4 + k);
            e.last = (k == 3);
            due_words.push_back(e);
         end
         quad_tally = quad_tally + 1'b1;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else if (push && !took_req) begin
         push <= 1'b1;
      end else if (rect_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         offer <= rect_queue[0];
         push <= 1'b1;
      end else begin
         push <= 1'b0;
      end
   end

   // result-side driver, with the long hold counted here
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = 300;
      end
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left != 0) begin
         pop <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      vertex_word_type got, want;
      took_req = 1'b0;
      if (!reset) begin
         if (push && !full) begin
            emit_quad_words(offer);
            void'(rect_queue.pop_front());
            took_req = 1'b1;
         end
         if (pop && !empty) begin
            got = {qvt_pkg::kind_type'(rsp_kind), rsp_vert_x, rsp_vert_y, rsp_vert_z,
                   rsp_color_word, rsp_vertex_slot, rsp_index_total, rsp_last};
            if (due_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected word kind=%0d x=%h y=%h z=%h", $realtime,
                           got.kind, got.vx, got.vy, got.vz);
            end else begin
               want = due_words.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display({"%0t: mismatch exp kind=%0d x=%h y=%h z=%h col=%h",
                               " slot=%0d idx=%0d last=%0d"},
                              $realtime, want.kind, want.vx, want.vy, want.vz, want.color,
                              want.slot, want.index, want.last);
                     $display({"%0t:          got kind=%0d x=%h y=%h z=%h col=%h",
                               " slot=%0d idx=%0d last=%0d"},
                              $realtime, got.kind, got.vx, got.vy, got.vz, got.color,
                              got.slot, got.index, got.last);
                  end
               end
            end
         end
      end
   end

   task automatic csr_write(input qvt_pkg::csr_reg_type r,
                            input logic [qvt_pkg::CSR_DATA_W-1:0] v);
      @(negedge clock);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {r, 3'b000};
      pwdata = v;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      case (r)
         qvt_pkg::REG_ROW_X:   mat_row[0] = v[qvt_pkg::ROW_W-1:0];
         qvt_pkg::REG_ROW_Y:   mat_row[1] = v[qvt_pkg::ROW_W-1:0];
         qvt_pkg::REG_ROW_Z:   mat_row[2] = v[qvt_pkg::ROW_W-1:0];
         qvt_pkg::REG_SHIFT_X: offset[0] = v[qvt_pkg::SHIFT_W-1:0];
         qvt_pkg::REG_SHIFT_Y: offset[1] = v[qvt_pkg::SHIFT_W-1:0];
         qvt_pkg::REG_SHIFT_Z: offset[2] = v[qvt_pkg::SHIFT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_xform(input logic [qvt_pkg::ROW_W-1:0] rx,
                            input logic [qvt_pkg::ROW_W-1:0] ry,
                            input logic [qvt_pkg::ROW_W-1:0] rz,
                            input logic [qvt_pkg::SHIFT_W-1:0] sx,
                            input logic [qvt_pkg::SHIFT_W-1:0] sy,
                            input logic [qvt_pkg::SHIFT_W-1:0] sz);
      csr_write(qvt_pkg::REG_ROW_X, 64'(rx));
      csr_write(qvt_pkg::REG_ROW_Y, 64'(ry));
      csr_write(qvt_pkg::REG_ROW_Z, 64'(rz));
      csr_write(qvt_pkg::REG_SHIFT_X, 64'(sx));
      csr_write(qvt_pkg::REG_SHIFT_Y, 64'(sy));
      csr_write(qvt_pkg::REG_SHIFT_Z, 64'(sz));
   endtask

   function automatic logic [qvt_pkg::COEF_W-1:0] rand_coef();
      if ($urandom_range(3) == 0) return qvt_pkg::COEF_W'($urandom);
      return qvt_pkg::COEF_W'($urandom_range(1024) - 512);
   endfunction

   function automatic logic [qvt_pkg::ROW_W-1:0] rand_row();
      return {rand_coef(), rand_coef(), rand_coef()};
   endfunction

   function automatic logic [qvt_pkg::SHIFT_W-1:0] rand_shift();
      if ($urandom_range(1) == 0) return $urandom;
      return qvt_pkg::SHIFT_W'($urandom_range(65536) - 32768);
   endfunction

   task automatic random_xform();
      set_xform(rand_row(), rand_row(), rand_row(), rand_shift(), rand_shift(), rand_shift());
   endtask

   function automatic logic [qvt_pkg::POS_W-1:0] rand_pos();
      if ($urandom_range(1) == 0) return qvt_pkg::POS_W'($urandom);
      return qvt_pkg::POS_W'($urandom_range(8191) - 4096);
   endfunction

   function automatic logic [qvt_pkg::CHAN_W-1:0] rand_chan();
      if ($urandom_range(4) == 0) return qvt_pkg::CHAN_W'($urandom_range(511));
      return qvt_pkg::CHAN_W'($urandom_range(256));
   endfunction

   function automatic rect_word_type mk_rect(input qvt_pkg::action_type act,
                                             input logic [qvt_pkg::POS_W-1:0] px,
                                             input logic [qvt_pkg::POS_W-1:0] py,
                                             input logic [qvt_pkg::POS_W-1:0] pz,
                                             input logic [qvt_pkg::POS_W-1:0] w,
                                             input logic [qvt_pkg::POS_W-1:0] h,
                                             input logic [qvt_pkg::CHAN_W-1:0] r,
                                             input logic [qvt_pkg::CHAN_W-1:0] g,
                                             input logic [qvt_pkg::CHAN_W-1:0] b,
                                             input logic [qvt_pkg::CHAN_W-1:0] a);
      rect_word_type t;
      t = {act, px, py, pz, w, h, r, g, b, a};
      return t;
   endfunction

   function automatic rect_word_type rand_submit();
      return mk_rect(qvt_pkg::ACT_SUBMIT, rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                     rand_pos(), rand_chan(), rand_chan(), rand_chan(), rand_chan());
   endfunction

   task automatic queue_random(input int n);
      rect_word_type t;
      int i;
      for (i = 0; i < n; i++) begin
         t = rand_submit();
         if ($urandom_range(7) == 0) t.action = qvt_pkg::ACT_FLUSH;
         rect_queue.push_back(t);
      end
   endtask

   task automatic queue_corners();
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_SUBMIT, POS_HI, POS_HI, POS_HI, POS_HI,
                                   POS_HI, 9'd256, 9'd256, 9'd256, 9'd256));
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_SUBMIT, POS_LO, POS_LO, POS_LO, POS_LO,
                                   POS_LO, 9'd0, 9'd0, 9'd0, 9'd0));
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_SUBMIT, POS_HI, POS_LO, POS_LO, POS_LO,
                                   POS_HI, 9'd511, 9'd257, 9'd255, 9'd1));
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_FLUSH, '0, '0, '0, '0, '0,
                                   '0, '0, '0, '0));
   endtask

   task automatic drain();
      while (rect_queue.size() != 0 || due_words.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // reset transform: empty flush, zero rect, field extremes, color clamps
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_FLUSH, '0, '0, '0, '0, '0,
                                   '0, '0, '0, '0));
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_SUBMIT, '0, '0, '0, '0, '0,
                                   '0, '0, '0, '0));
      queue_corners();
      rect_queue.push_back(mk_rect(qvt_pkg::ACT_SUBMIT, 24'sd256, -24'sd512, 24'sd1024,
                                   -24'sd1, 24'sd1, 9'd128, 9'd64, 9'd511, 9'd384));
      drain();

      // saturation both ways
      set_xform({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      queue_corners();
      drain();
      set_xform({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                32'h80000000, 32'h80000000, 32'h80000000);
      queue_corners();
      drain();

      // random traffic; first phase backs the block up with a long hold
      random_xform();
      queue_random(50);
      hold_req++;
      drain();

      send_idle_pct = 60;
      random_xform();
      queue_random(50);
      drain();

      send_idle_pct = 0;
      recv_stall_pct = 60;
      set_xform('0, '0, '0, '0, '0, '0);
      queue_random(50);
      drain();

      send_idle_pct = 9;
      recv_stall_pct = 9;
      random_xform();
      queue_random(50);
      drain();

      repeat (20) @(negedge clock);
      if (due_words.size() != 0) errors++;
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
